// ----- rtl/hsvrgb_pkg.sv -----
// Package for the HSV to RGB pixel converter: item structs, sector codes
// and the fixed-point constants. No dependencies.
package hsvrgb_pkg;

    // One input item: hue in degrees times 64, saturation and value in Q15.
    typedef struct packed {
        logic [14:0] hue;
        logic [15:0] saturation;
        logic [15:0] brightness;
    } t_hsv_pixel;

    // One result item: three 8-bit channels.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb_pixel;

    // Sixty-degree hue sectors.
    typedef enum logic [2:0] {
        SEC_RED_TO_YEL = 3'd0,
        SEC_YEL_TO_GRN = 3'd1,
        SEC_GRN_TO_CYN = 3'd2,
        SEC_CYN_TO_BLU = 3'd3,
        SEC_BLU_TO_MAG = 3'd4,
        SEC_MAG_TO_RED = 3'd5
    } t_sector;

    // 1.0 in Q15.
    localparam logic [15:0] FULL_Q15     = 16'd32768;
    // One sector, 60 degrees times 64.
    localparam logic [11:0] SECTOR_UNITS = 12'd3840;
    // Full turn, 360 degrees times 64.
    localparam logic [14:0] FULL_TURN    = 15'd23040;
    // 1.0 for a channel fraction: FULL_Q15 * SECTOR_UNITS.
    localparam logic [26:0] FULL_FRAC    = 27'd125829120;
    // Reciprocal of 15 in 1/65536 units, rounded up; exact below 4096.
    localparam logic [12:0] RECIP_15     = 13'd4370;

endpackage

// ----- rtl/hsv_to_rgb_pixel.sv -----
// Top level of the HSV to RGB pixel converter, a six-stage pipeline.
// Depends on hsvrgb_pkg for the item structs, sector codes and constants.
//
//  Channel | Valid       | Stall        | Payload
//  --------+-------------+--------------+--------------------------
//  input   | i_in_valid  | o_in_stall   | i_in_data  (t_hsv_pixel)
//  output  | o_out_valid | i_out_stall  | o_out_data (t_rgb_pixel)
//
// An item passes the stage 1 to 6 registers on its way to the output, and
// one item can enter in every cycle while o_in_stall is low. The depth is
// set by the two multiplier stages and the times 255 and /(2^38*15) tail.
// Reset clears only the stage valid bits; no item survives reset.
// A stall on the output holds the last stage; earlier stages keep moving
// into empty slots, and o_in_stall rises only when every stage is full.
module hsv_to_rgb_pixel
    import hsvrgb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_hsv_pixel i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_rgb_pixel o_out_data
);

    // Stage valid bits and per-stage advance enables.
    logic [6:1] r_vld;
    logic [7:1] w_adv;

    // Stage 1 registers: clamped inputs, sector and fraction.
    logic [15:0] r1_sat;
    logic [15:0] r1_val;
    t_sector     r1_sec;
    logic [11:0] r1_frac;

    // Stage 2 registers: saturation products.
    logic [27:0] r2_sf;
    logic [27:0] r2_sg;
    logic [27:0] r2_ss;
    logic [15:0] r2_val;
    t_sector     r2_sec;

    // Stage 3 registers: channel fractions over FULL_FRAC.
    logic [26:0] r3_xr;
    logic [26:0] r3_xg;
    logic [26:0] r3_xb;
    logic [15:0] r3_val;

    // Stage 4 registers: value times fraction.
    logic [42:0] r4_mr;
    logic [42:0] r4_mg;
    logic [42:0] r4_mb;

    // Stage 5 registers: 255 times product, shifted down by 2^38.
    logic [11:0] r5_qr;
    logic [11:0] r5_qg;
    logic [11:0] r5_qb;

    // Stage 6 register: the result item.
    t_rgb_pixel  r6_rgb;

    // A stage advances when it is empty or the stage after it advances.
    always_comb begin
        w_adv[7] = !i_out_stall;
        for (int k = 6; k >= 1; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign o_in_stall  = !w_adv[1];
    assign o_out_valid = r_vld[6];
    assign o_out_data  = r6_rgb;

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[1]) r_vld[1] <= i_in_valid;
            for (int k = 2; k <= 6; k++) begin
                if (w_adv[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Stage 1: clamp, wrap the hue once and split it into sector and fraction.
    logic [15:0] w_sat;
    logic [15:0] w_val;
    logic [14:0] w_hue;
    logic [14:0] w_base;
    logic [14:0] w_frac15;
    t_sector     w_sec;

    always_comb begin
        w_sat = (i_in_data.saturation > FULL_Q15) ? FULL_Q15 : i_in_data.saturation;
        w_val = (i_in_data.brightness > FULL_Q15) ? FULL_Q15 : i_in_data.brightness;
        w_hue = (i_in_data.hue >= FULL_TURN) ? (i_in_data.hue - FULL_TURN)
                                             : i_in_data.hue;
        if (w_hue >= 15'(5 * SECTOR_UNITS)) begin
            w_sec  = SEC_MAG_TO_RED;
            w_base = 15'(5 * SECTOR_UNITS);
        end else if (w_hue >= 15'(4 * SECTOR_UNITS)) begin
            w_sec  = SEC_BLU_TO_MAG;
            w_base = 15'(4 * SECTOR_UNITS);
        end else if (w_hue >= 15'(3 * SECTOR_UNITS)) begin
            w_sec  = SEC_CYN_TO_BLU;
            w_base = 15'(3 * SECTOR_UNITS);
        end else if (w_hue >= 15'(2 * SECTOR_UNITS)) begin
            w_sec  = SEC_GRN_TO_CYN;
            w_base = 15'(2 * SECTOR_UNITS);
        end else if (w_hue >= 15'(SECTOR_UNITS)) begin
            w_sec  = SEC_YEL_TO_GRN;
            w_base = 15'(SECTOR_UNITS);
        end else begin
            w_sec  = SEC_RED_TO_YEL;
            w_base = '0;
        end
        w_frac15 = w_hue - w_base;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r1_sat  <= w_sat;
            r1_val  <= w_val;
            r1_sec  <= w_sec;
            r1_frac <= w_frac15[11:0];
        end
    end

    // Stage 2: s*f, s*(1-f) and s, all in 1/SECTOR_UNITS units.
    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r2_sf  <= 28'(r1_sat) * 28'(r1_frac);
            r2_sg  <= 28'(r1_sat) * 28'(SECTOR_UNITS - r1_frac);
            r2_ss  <= 28'(r1_sat) * 28'(SECTOR_UNITS);
            r2_val <= r1_val;
            r2_sec <= r1_sec;
        end
    end

    // Stage 3: p, q and t fractions, then the sector picks channel order.
    // With zero saturation all fractions equal 1.0, which gives grey.
    logic [26:0] w_xv;
    logic [26:0] w_xp;
    logic [26:0] w_xq;
    logic [26:0] w_xt;
    logic [26:0] w_xr;
    logic [26:0] w_xg;
    logic [26:0] w_xb;

    always_comb begin
        w_xv = FULL_FRAC;
        w_xp = 27'(28'(FULL_FRAC) - r2_ss);
        w_xq = 27'(28'(FULL_FRAC) - r2_sf);
        w_xt = 27'(28'(FULL_FRAC) - r2_sg);
        case (r2_sec)
            SEC_RED_TO_YEL: begin w_xr = w_xv; w_xg = w_xt; w_xb = w_xp; end
            SEC_YEL_TO_GRN: begin w_xr = w_xq; w_xg = w_xv; w_xb = w_xp; end
            SEC_GRN_TO_CYN: begin w_xr = w_xp; w_xg = w_xv; w_xb = w_xt; end
            SEC_CYN_TO_BLU: begin w_xr = w_xp; w_xg = w_xq; w_xb = w_xv; end
            SEC_BLU_TO_MAG: begin w_xr = w_xt; w_xg = w_xp; w_xb = w_xv; end
            default:        begin w_xr = w_xv; w_xg = w_xp; w_xb = w_xq; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            r3_xr  <= w_xr;
            r3_xg  <= w_xg;
            r3_xb  <= w_xb;
            r3_val <= r2_val;
        end
    end

    // Stage 4: scale each fraction by the value.
    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            r4_mr <= 43'(r3_val) * 43'(r3_xr);
            r4_mg <= 43'(r3_val) * 43'(r3_xg);
            r4_mb <= 43'(r3_val) * 43'(r3_xb);
        end
    end

    // Stage 5: times 255 as a shift and subtract, then drop 38 bits.
    // The full denominator is 2^38 * 15, so what remains is below 3840.
    logic [50:0] w_ar;
    logic [50:0] w_ag;
    logic [50:0] w_ab;

    always_comb begin
        w_ar = {r4_mr, 8'd0} - 51'(r4_mr);
        w_ag = {r4_mg, 8'd0} - 51'(r4_mg);
        w_ab = {r4_mb, 8'd0} - 51'(r4_mb);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[5]) begin
            r5_qr <= w_ar[49:38];
            r5_qg <= w_ag[49:38];
            r5_qb <= w_ab[49:38];
        end
    end

    // Stage 6: divide by 15 through its reciprocal and truncate.
    logic [24:0] w_yr;
    logic [24:0] w_yg;
    logic [24:0] w_yb;

    always_comb begin
        w_yr = 25'(r5_qr) * 25'(RECIP_15);
        w_yg = 25'(r5_qg) * 25'(RECIP_15);
        w_yb = 25'(r5_qb) * 25'(RECIP_15);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[6]) begin
            r6_rgb.red   <= w_yr[23:16];
            r6_rgb.green <= w_yg[23:16];
            r6_rgb.blue  <= w_yb[23:16];
        end
    end

    // The input is held off only when every stage holds an item.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_vld == 6'b111111))
        else $error("input stalled with an empty pipeline stage");

    // The hue fraction stays inside one sector.
    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> (r1_frac < SECTOR_UNITS))
        else $error("hue fraction outside its sector");

    // Every sector puts the full value on one channel.
    a_value_chan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] |-> (r3_xr == FULL_FRAC || r3_xg == FULL_FRAC || r3_xb == FULL_FRAC))
        else $error("no channel carries the full value");

endmodule

// ----- dv/hsvrgb_tb_pkg.sv -----
`timescale 1ns / 100ps
// Pixel color checker for the HSV to RGB converter testbench: an exact
// integer prediction of each pixel and an in-order compare of the results.
// Depends on hsvrgb_pkg for the item structs, sector codes and constants.
package hsvrgb_tb_pkg;
    import hsvrgb_pkg::*;

    // Every channel fraction is held as a numerator over this denominator.
    localparam longint unsigned CHAN_DEN  = 64'(FULL_Q15) * 64'(FULL_Q15) * 64'(SECTOR_UNITS);
    localparam longint unsigned CHAN_MAX  = 64'd255;
    localparam longint unsigned Q15_ONE   = 64'(FULL_Q15);
    localparam longint unsigned FRAC_ONE  = 64'(FULL_FRAC);
    localparam longint unsigned SECT_SIZE = 64'(SECTOR_UNITS);
    localparam longint unsigned TURN_SIZE = 64'(FULL_TURN);

    class pixel_color_checker;
        t_rgb_pixel  rgb_expected[$];
        int unsigned mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        // Scale an exact fraction by 255 and truncate toward zero.
        function logic [7:0] to_channel(longint unsigned num);
            return 8'((CHAN_MAX * num) / CHAN_DEN);
        endfunction

        // Exact conversion of one pixel in integer arithmetic.
        function t_rgb_pixel convert_hsv(t_hsv_pixel px);
            longint unsigned hue_u, sat, val, frac;
            longint unsigned n_v, n_p, n_q, n_t;
            longint unsigned chan_r, chan_g, chan_b;
            t_sector         sector;
            t_rgb_pixel      rgb;
            hue_u = px.hue;
            sat   = px.saturation;
            val   = px.brightness;

            // Fractions above 1.0 saturate.
            if (sat > Q15_ONE) begin
                sat = Q15_ONE;
            end
            if (val > Q15_ONE) begin
                val = Q15_ONE;
            end
            n_v = val * FRAC_ONE;

            // Zero saturation is grey: every channel follows the value.
            if (sat == 0) begin
                rgb.red   = to_channel(n_v);
                rgb.green = rgb.red;
                rgb.blue  = rgb.red;
                return rgb;
            end

            // Hue wraps once modulo a full turn, then splits into sector and fraction.
            if (hue_u >= TURN_SIZE) begin
                hue_u = hue_u - TURN_SIZE;
            end
            sector = t_sector'(hue_u / SECT_SIZE);
            frac   = hue_u % SECT_SIZE;
            n_p    = val * (Q15_ONE - sat) * SECT_SIZE;
            n_q    = val * (FRAC_ONE - sat * frac);
            n_t    = val * (FRAC_ONE - sat * (SECT_SIZE - frac));

            // The sector picks the channel order.
            case (sector)
                SEC_RED_TO_YEL: begin
                    chan_r = n_v; chan_g = n_t; chan_b = n_p;
                end
                SEC_YEL_TO_GRN: begin
                    chan_r = n_q; chan_g = n_v; chan_b = n_p;
                end
                SEC_GRN_TO_CYN: begin
                    chan_r = n_p; chan_g = n_v; chan_b = n_t;
                end
                SEC_CYN_TO_BLU: begin
                    chan_r = n_p; chan_g = n_q; chan_b = n_v;
                end
                SEC_BLU_TO_MAG: begin
                    chan_r = n_t; chan_g = n_p; chan_b = n_v;
                end
                default: begin
                    chan_r = n_v; chan_g = n_p; chan_b = n_q;
                end
            endcase
            rgb.red   = to_channel(chan_r);
            rgb.green = to_channel(chan_g);
            rgb.blue  = to_channel(chan_b);
            return rgb;
        endfunction

        // An item went into the block: queue its expected pixel.
        function void note_pixel(t_hsv_pixel px);
            rgb_expected.push_back(convert_hsv(px));
        endfunction

        // A result came out: compare it with the oldest expected pixel.
        function void check_pixel(t_rgb_pixel got);
            t_rgb_pixel want;
            if (rgb_expected.size() == 0) begin
                $error("unexpected result item: red %0d, green %0d, blue %0d",
                       got.red, got.green, got.blue);
                mismatch_count++;
                return;
            end
            want = rgb_expected.pop_front();
            if (got.red !== want.red) begin
                $error("red: expected %0d, actual %0d", want.red, got.red);
                mismatch_count++;
            end
            if (got.green !== want.green) begin
                $error("green: expected %0d, actual %0d", want.green, got.green);
                mismatch_count++;
            end
            if (got.blue !== want.blue) begin
                $error("blue: expected %0d, actual %0d", want.blue, got.blue);
                mismatch_count++;
            end
        endfunction

        function int unsigned pending();
            return rgb_expected.size();
        endfunction
    endclass

endpackage

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// Top of the HSV to RGB converter testbench: clock, reset, item drivers,
// random stalls and the final verdict. Depends on hsvrgb_pkg, hsvrgb_tb_pkg
// and the hsv_to_rgb_pixel RTL.
module tb_top;
    import hsvrgb_pkg::*;
    import hsvrgb_tb_pkg::*;

    typedef enum int {
        PH_FREE,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH,
        PH_HOLD
    } t_phase;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_hsv_pixel i_in_data;
    logic       o_out_valid;
    logic       i_out_stall;
    t_rgb_pixel o_out_data;

    t_phase             phase = PH_FREE;
    pixel_color_checker pixel_check = new();

    hsv_to_rgb_pixel u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Clock with a 2 ns period.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard limit on the run, far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int unsigned send_idle_pct(t_phase p);
        case (p)
            PH_SEND_IDLE: return 82;
            PH_BOTH:      return 14;
            default:      return 0;
        endcase
    endfunction

    function automatic int unsigned recv_stall_pct(t_phase p);
        case (p)
            PH_RECV_STALL: return 82;
            PH_BOTH:       return 14;
            default:       return 0;
        endcase
    endfunction

    function automatic t_hsv_pixel make_pixel(int unsigned hue, int unsigned sat,
                                              int unsigned val);
        t_hsv_pixel px;
        px.hue        = 15'(hue);
        px.saturation = 16'(sat);
        px.brightness = 16'(val);
        return px;
    endfunction

    // Hue: mostly the nominal range, some out of range, some sector edges.
    function automatic logic [14:0] random_hue();
        int unsigned pick;
        int unsigned k;
        pick = $urandom_range(9);
        k    = $urandom_range(6);
        if (pick < 6) begin
            return 15'($urandom_range(FULL_TURN));
        end else if (pick < 8) begin
            return 15'($urandom_range(32767));
        end else if (pick == 8 || k == 0) begin
            return 15'(k * SECTOR_UNITS);
        end
        return 15'(k * SECTOR_UNITS - 1);
    endfunction

    // Fraction: mostly 0 to 1.0, with the full 16-bit range and the edges.
    function automatic logic [15:0] random_fraction();
        int unsigned pick;
        pick = $urandom_range(9);
        case (pick)
            6:       return 16'($urandom_range(65535));
            7:       return 16'd0;
            8:       return FULL_Q15;
            9:       return 16'($urandom_range(16));
            default: return 16'($urandom_range(FULL_Q15));
        endcase
    endfunction

    // Offer one item, idling first as the phase asks, and wait until taken.
    task automatic send_pixel(t_hsv_pixel px);
        while ($urandom_range(99) < send_idle_pct(phase)) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= px;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
    endtask

    task automatic run_phase(t_phase p, int unsigned count);
        t_hsv_pixel px;
        phase = p;
        repeat (count) begin
            px.hue        = random_hue();
            px.saturation = random_fraction();
            px.brightness = random_fraction();
            send_pixel(px);
        end
    endtask

    // Receiver: random stalls per phase, plus one long hold-off so the
    // pipeline fills and pushes back on its input.
    initial begin : recv_side
        int unsigned hold_left;
        bit          hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (phase == PH_HOLD && !hold_done) begin
                hold_left = 400;
                hold_done = 1'b1;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct(phase));
            end
        end
    end

    // Watch both channels and hand every accepted item to the checker.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            pixel_check.note_pixel(i_in_data);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            pixel_check.check_pixel(o_out_data);
        end
    end

    // Reset, directed pixels, random phases, drain and verdict.
    initial begin : stimulus
        int unsigned drain_cycles;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: black, grey, saturated inputs, and every sector edge.
        phase = PH_FREE;
        send_pixel(make_pixel(0, 0, 0));
        send_pixel(make_pixel(0, 0, 32768));
        send_pixel(make_pixel(12345, 0, 65535));
        send_pixel(make_pixel(0, 32768, 32768));
        send_pixel(make_pixel(3839, 32768, 32768));
        send_pixel(make_pixel(3840, 32768, 32768));
        send_pixel(make_pixel(7680, 32768, 32768));
        send_pixel(make_pixel(11520, 32768, 32768));
        send_pixel(make_pixel(15360, 32768, 32768));
        send_pixel(make_pixel(19200, 32768, 32768));
        send_pixel(make_pixel(23039, 32768, 32768));
        // A hue of exactly a full turn and hues beyond it wrap around.
        send_pixel(make_pixel(23040, 32768, 32768));
        send_pixel(make_pixel(23041, 20000, 30000));
        send_pixel(make_pixel(32767, 65535, 65535));
        send_pixel(make_pixel(5000, 16384, 20000));
        send_pixel(make_pixel(9000, 32769, 32768));
        send_pixel(make_pixel(17000, 1, 32768));
        send_pixel(make_pixel(21000, 32768, 1));
        send_pixel(make_pixel(1920, 16384, 32767));
        send_pixel(make_pixel(13440, 30000, 65535));

        // Random phases with different idle and stall mixes.
        run_phase(PH_FREE, 350);
        run_phase(PH_SEND_IDLE, 300);
        run_phase(PH_RECV_STALL, 300);
        run_phase(PH_BOTH, 300);
        run_phase(PH_HOLD, 200);
        run_phase(PH_FREE, 200);
        i_in_valid <= 1'b0;

        // Drain the pipeline, then keep watching for stray results.
        phase = PH_FREE;
        drain_cycles = 0;
        while (pixel_check.pending() != 0 && drain_cycles < 100000) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (20) @(posedge i_clk);

        if (pixel_check.mismatch_count == 0 && pixel_check.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/hsvrgb_pkg.sv
rtl/hsv_to_rgb_pixel.sv
dv/hsvrgb_tb_pkg.sv
dv/tb_top.sv
